// ----- sv/fde_pkg.sv -----
package fde_pkg;

  // Field widths of the command and result channels.
  localparam int CMD_W    = 3;
  localparam int COORD_W  = 10;
  localparam int COLOUR_W = 16;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PIXEL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCREEN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WOPEN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IMAGE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_WIN  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNUSED  = 2'd3;

  // One result as it travels to the output buffer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COLOUR_W-1:0] read_word;
  } res_t;

endpackage

// ----- sv/fde_if.sv -----
// Command channel: one drawing request.
interface fde_req_if;
  logic                         valid;
  logic                         ready;
  logic [fde_pkg::CMD_W-1:0]    cmd;
  logic [fde_pkg::COORD_W-1:0]  pos_x;
  logic [fde_pkg::COORD_W-1:0]  pos_y;
  logic [fde_pkg::COORD_W-1:0]  size_w;
  logic [fde_pkg::COORD_W-1:0]  size_h;
  logic [fde_pkg::COLOUR_W-1:0] colour;

  modport source (output valid, cmd, pos_x, pos_y, size_w, size_h, colour, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, size_w, size_h, colour, output ready);
endinterface

// Result channel: one status word per request.
interface fde_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fde_pkg::STATUS_W-1:0] status;
  logic [fde_pkg::COLOUR_W-1:0] read_word;

  modport source (output valid, status, read_word, input ready);
  modport sink (input valid, status, read_word, output ready);
endinterface

// ----- sv/fde_frame_mem.sv -----
module fde_frame_mem #(
  parameter int DEPTH  = 12800,
  parameter int ADDR_W = 14
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            addr,
  input  logic [fde_pkg::COLOUR_W-1:0] wdata,
  output logic [fde_pkg::COLOUR_W-1:0] rdata
);
  import fde_pkg::*;

  logic [COLOUR_W-1:0] mem [DEPTH];

  // Single port, registered read of the addressed word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/fde_out_buf.sv -----
module fde_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fde_pkg::res_t push_data,
  output logic          free,
  fde_rsp_if.source     result
);
  import fde_pkg::*;

  logic valid;
  res_t data;

  // The slot can be loaded when empty or when its result leaves now.
  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

  assign result.valid     = valid;
  assign result.status    = data.status;
  assign result.read_word = data.read_word;

endmodule

// ----- sv/framebuffer_draw_engine_core.sv -----
// Framebuffer draw engine: an RGB565 frame store of SCREEN_W x SCREEN_H words,
// each kept byte-swapped. Requests arrive on req and each gives exactly one
// result on the result channel, in request order.
// After reset the engine clears the frame store, one word a cycle, through all
// SCREEN_W*SCREEN_H words (12800 at the defaults); req.ready stays low then.
// Requests are taken one at a time; ready is high only while the engine idles.
// States from acceptance until the finish state loads the result into the
// output register: execute alone for a pixel, window open, image pixel,
// unused code, off-screen read or empty rectangle; execute and read-wait for
// a read on screen; for a rectangle, execute and the rectangle state, which
// writes clipped width * clipped height words; for a fill, execute and the
// screen state. A new request is taken only once the previous result is loaded
// and the engine is back in its idle state, so requests never overlap.
// The single memory port, written once per cycle, sets the fill rates.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and processed, and its result waits inside the
// engine until the output register is free.
module framebuffer_draw_engine_core #(
  parameter int SCREEN_W = 160,
  parameter int SCREEN_H = 80
) (
  input logic       clk,
  input logic       rst,
  fde_req_if.sink   req,
  fde_rsp_if.source result
);
  import fde_pkg::*;

  localparam int DEPTH  = SCREEN_W * SCREEN_H;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0]  W_A      = ADDR_W'(SCREEN_W);
  localparam logic [ADDR_W-1:0]  LAST_A   = ADDR_W'(DEPTH - 1);
  localparam logic [COORD_W:0]   W_E      = (COORD_W + 1)'(SCREEN_W);
  localparam logic [COORD_W:0]   H_E      = (COORD_W + 1)'(SCREEN_H);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RECT   = 3'd3;
  localparam logic [2:0] S_SCREEN = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  function automatic logic [COLOUR_W-1:0] wire_order(input logic [COLOUR_W-1:0] c);
    wire_order = {c[7:0], c[15:8]};
  endfunction

  logic [2:0]          state, state_next;

  // Latched request.
  logic [CMD_W-1:0]    cmd_r;
  logic [COORD_W-1:0]  x_r, y_r, w_r, h_r;
  logic [COLOUR_W-1:0] colour_r;

  // Window and cursor.
  logic [COORD_W-1:0]  win_x, win_y, win_w, win_h;
  logic [COORD_W-1:0]  cursor_col, cursor_row;
  logic                window_open;

  // Sweep counters.
  logic [COORD_W-1:0]  cnt_col, cnt_row, w_lim, h_lim;
  logic [ADDR_W-1:0]   row_base, addr_cnt;

  // Pending result.
  res_t                res;

  // Memory port.
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [COLOUR_W-1:0] mem_wdata, mem_rdata;

  logic                buf_free, buf_push;

  fde_frame_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fde_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (buf_push),
    .push_data (res),
    .free      (buf_free),
    .result    (result)
  );

  assign req.ready = (state == S_IDLE);
  assign buf_push  = (state == S_FINISH) && buf_free;

  // Geometry of the latched request.
  logic [COORD_W:0]    x_end, y_end, img_x, img_y;
  logic                on;
  logic [COORD_W-1:0]  w_clip, h_clip;
  logic                win_ok;

  always_comb begin
    x_end  = {1'b0, x_r} + {1'b0, w_r};
    y_end  = {1'b0, y_r} + {1'b0, h_r};
    on     = ({1'b0, x_r} < W_E) && ({1'b0, y_r} < H_E);
    w_clip = (x_end > W_E) ? COORD_W'(W_E - {1'b0, x_r}) : w_r;
    h_clip = (y_end > H_E) ? COORD_W'(H_E - {1'b0, y_r}) : h_r;
    win_ok = on && (x_end <= W_E) && (y_end <= H_E) && (w_r != '0) && (h_r != '0);
    img_x  = {1'b0, win_x} + {1'b0, cursor_col};
    img_y  = {1'b0, win_y} + {1'b0, cursor_row};
  end

  // One shared row-times-width multiplier for pixel, read and image addresses and the rectangle's first row.
  logic [COORD_W:0]    sel_row, sel_col;
  logic [ADDR_W-1:0]   point_addr;

  always_comb begin
    if (cmd_r == CMD_IMAGE) begin
      sel_row = img_y;
      sel_col = img_x;
    end else begin
      sel_row = {1'b0, y_r};
      sel_col = {1'b0, x_r};
    end
    point_addr = ADDR_W'(sel_row) * W_A + ADDR_W'(sel_col);
  end

  // Image cursor advance.
  logic [COORD_W-1:0]  ncol, nrow;
  logic                row_end, win_end;

  always_comb begin
    ncol    = cursor_col + 1'b1;
    nrow    = cursor_row + 1'b1;
    row_end = (ncol >= win_w);
    win_end = row_end && (nrow >= win_h);
  end

  // Sequencer: memory port and next state.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = point_addr;
    mem_wdata  = colour_r;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = addr_cnt;
        mem_wdata = '0;
        if (addr_cnt == LAST_A) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (cmd_r)
          CMD_PIXEL: begin
            mem_we = on;
          end
          CMD_RECT: begin
            if (on && (w_clip != '0) && (h_clip != '0)) begin
              state_next = S_RECT;
            end
          end
          CMD_SCREEN: begin
            state_next = S_SCREEN;
          end
          CMD_IMAGE: begin
            mem_we = window_open;
          end
          CMD_READ: begin
            if (on) begin
              state_next = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_RECT: begin
        mem_we   = 1'b1;
        mem_addr = row_base + ADDR_W'(cnt_col);
        if ((cnt_col == w_lim - 1'b1) && (cnt_row == h_lim - 1'b1)) begin
          state_next = S_FINISH;
        end
      end
      S_SCREEN: begin
        mem_we   = 1'b1;
        mem_addr = addr_cnt;
        if (addr_cnt == LAST_A) begin
          state_next = S_FINISH;
        end
      end
      S_RDWAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (buf_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      addr_cnt    <= '0;
      win_x       <= '0;
      win_y       <= '0;
      win_w       <= '0;
      win_h       <= '0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      window_open <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_SCREEN) begin
        addr_cnt <= addr_cnt + 1'b1;
      end else begin
        addr_cnt <= '0;
      end
      if (state == S_EXEC && cmd_r == CMD_WOPEN) begin
        window_open <= win_ok;
        if (win_ok) begin
          win_x      <= x_r;
          win_y      <= y_r;
          win_w      <= w_r;
          win_h      <= h_r;
          cursor_col <= '0;
          cursor_row <= '0;
        end
      end
      if (state == S_EXEC && cmd_r == CMD_IMAGE && window_open) begin
        cursor_col <= row_end ? '0 : ncol;
        if (row_end) begin
          cursor_row <= win_end ? '0 : nrow;
        end
        if (win_end) begin
          window_open <= 1'b0;
        end
      end
    end
  end

  // Request latch, rectangle sweep and pending result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd_r    <= req.cmd;
      x_r      <= req.pos_x;
      y_r      <= req.pos_y;
      w_r      <= req.size_w;
      h_r      <= req.size_h;
      colour_r <= wire_order(req.colour);
    end
    case (state)
      S_EXEC: begin
        cnt_col       <= '0;
        cnt_row       <= '0;
        w_lim         <= w_clip;
        h_lim         <= h_clip;
        row_base      <= point_addr;
        res.read_word <= '0;
        case (cmd_r)
          CMD_PIXEL:  res.status <= on ? STAT_DONE : STAT_NONE;
          CMD_RECT:   res.status <= (on && (w_clip != '0) && (h_clip != '0)) ?
                                    STAT_DONE : STAT_NONE;
          CMD_SCREEN: res.status <= STAT_DONE;
          CMD_WOPEN:  res.status <= win_ok ? STAT_DONE : STAT_NONE;
          CMD_IMAGE:  res.status <= window_open ? STAT_DONE : STAT_NO_WIN;
          CMD_READ:   res.status <= on ? STAT_DONE : STAT_NONE;
          default:    res.status <= STAT_NONE;
        endcase
      end
      S_RECT: begin
        if (cnt_col == w_lim - 1'b1) begin
          cnt_col  <= '0;
          cnt_row  <= cnt_row + 1'b1;
          row_base <= row_base + W_A;
        end else begin
          cnt_col <= cnt_col + 1'b1;
        end
      end
      S_RDWAIT: begin
        res.read_word <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/fde_checker.sv -----
module fde_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fde_pkg::STATUS_W-1:0] status,
  input logic [fde_pkg::COLOUR_W-1:0] read_word
);
  import fde_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The frame store is being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken during the clearing pass");

  // Requests are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != STAT_UNUSED)
    else $error("undefined status code");

  // Read data is returned only with a successful status.
  a_read_word_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_word != '0) |-> status == STAT_DONE)
    else $error("read data with a failing status");

endmodule

bind framebuffer_draw_engine_core fde_checker u_fde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .status    (result.status),
  .read_word (result.read_word)
);

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fde_pkg::*;

  localparam int SCREEN_W = 160;
  localparam int SCREEN_H = 80;
  localparam int FB_WORDS = SCREEN_W * SCREEN_H;
  localparam int RANDOM_REQS = 1950;
  localparam int SETTLE_CYCLES = 32;

  // Command codes that the engine does not define.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  w;
    logic [COORD_W-1:0]  h;
    logic [COLOUR_W-1:0] colour;
  } draw_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fde_req_if req_bus ();
  fde_rsp_if rsp_bus ();

  framebuffer_draw_engine_core #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .result(rsp_bus)
  );

  always #5 clk = ~clk;

  // Requests waiting to be sent, and results owed by the engine.
  draw_req_t pending_reqs[$];
  res_t      owed_results[$];
  draw_req_t on_bus;
  res_t      due;

  int src_idle_pct;
  int sink_stall_pct;
  int queued_total;
  int mismatches;
  int compared;
  int sent_by_cmd[8];

  // Shadow copy of the frame store and the image window.
  logic [COLOUR_W-1:0] fb_shadow[FB_WORDS];
  logic [COORD_W-1:0]  win_x, win_y, win_w, win_h;
  logic [COORD_W-1:0]  cur_col, cur_row;
  logic                win_open;

  function automatic void add_req(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                  input int w, input int h, input int colour);
    draw_req_t r;
    r.cmd    = cmd;
    r.x      = COORD_W'(x);
    r.y      = COORD_W'(y);
    r.w      = COORD_W'(w);
    r.h      = COORD_W'(h);
    r.colour = COLOUR_W'(colour);
    pending_reqs.push_back(r);
    queued_total++;
  endfunction

  // Apply one accepted request to the shadow state and record the result it owes.
  task automatic apply_draw(input draw_req_t r);
    int x, y, w, h, row, col;
    logic on_screen;
    logic [COLOUR_W-1:0] swapped;
    res_t res;
    x = int'(r.x);
    y = int'(r.y);
    w = int'(r.w);
    h = int'(r.h);
    on_screen = (x < SCREEN_W) && (y < SCREEN_H);
    swapped = {r.colour[7:0], r.colour[15:8]};
    res.status = STAT_NONE;
    res.read_word = '0;
    case (r.cmd)
      CMD_PIXEL: begin
        if (on_screen) begin
          fb_shadow[y * SCREEN_W + x] = swapped;
          res.status = STAT_DONE;
        end
      end
      CMD_RECT: begin
        if (on_screen) begin
          if (x + w > SCREEN_W) w = SCREEN_W - x;
          if (y + h > SCREEN_H) h = SCREEN_H - y;
          if (w != 0 && h != 0) begin
            for (row = y; row < y + h; row++)
              for (col = x; col < x + w; col++)
                fb_shadow[row * SCREEN_W + col] = swapped;
            res.status = STAT_DONE;
          end
        end
      end
      CMD_SCREEN: begin
        for (col = 0; col < FB_WORDS; col++) fb_shadow[col] = swapped;
        res.status = STAT_DONE;
      end
      CMD_WOPEN: begin
        if (on_screen && x + w <= SCREEN_W && y + h <= SCREEN_H && w != 0 && h != 0) begin
          win_x = r.x;
          win_y = r.y;
          win_w = r.w;
          win_h = r.h;
          cur_col = '0;
          cur_row = '0;
          win_open = 1'b1;
          res.status = STAT_DONE;
        end else begin
          win_open = 1'b0;
        end
      end
      CMD_IMAGE: begin
        if (!win_open) begin
          res.status = STAT_NO_WIN;
        end else begin
          col = int'(win_x) + int'(cur_col);
          row = int'(win_y) + int'(cur_row);
          if (col < SCREEN_W && row < SCREEN_H) fb_shadow[row * SCREEN_W + col] = swapped;
          cur_col = cur_col + 1'b1;
          if (cur_col >= win_w) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            if (cur_row >= win_h) begin
              cur_row = '0;
              win_open = 1'b0;
            end
          end
          res.status = STAT_DONE;
        end
      end
      CMD_READ: begin
        if (on_screen) begin
          res.read_word = fb_shadow[y * SCREEN_W + x];
          res.status = STAT_DONE;
        end
      end
      default: ;
    endcase
    owed_results.push_back(res);
  endtask

  // Random traffic, mostly complete image windows with other commands mixed in.
  task automatic queue_random(input int target);
    int pick, wx, wy, ww, wh, npix, k, last_x, last_y;
    last_x = 0;
    last_y = 0;
    while (queued_total < target) begin
      pick = $urandom_range(999);
      if (pick < 300) begin
        ww = $urandom_range(8, 1);
        wh = $urandom_range(6, 1);
        if ($urandom_range(19) == 0) begin
          ww = $urandom_range(SCREEN_W, 1);
          wh = 1;
        end
        wx = ($urandom_range(3) == 0) ? SCREEN_W - ww : $urandom_range(SCREEN_W - ww);
        wy = ($urandom_range(3) == 0) ? SCREEN_H - wh : $urandom_range(SCREEN_H - wh);
        add_req(CMD_WOPEN, wx, wy, ww, wh, $urandom);
        npix = ww * wh;
        // Now and then the stream stops early and the window is left open.
        if ($urandom_range(9) == 0) npix = $urandom_range(npix - 1);
        for (k = 0; k < npix; k++) begin
          if ($urandom_range(11) == 0)
            add_req(CMD_READ, wx + $urandom_range(ww - 1), wy + $urandom_range(wh - 1),
                    $urandom, $urandom, $urandom);
          add_req(CMD_IMAGE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        if ($urandom_range(3) == 0)
          add_req(CMD_IMAGE, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2))
          add_req(CMD_READ, wx + $urandom_range(ww - 1), wy + $urandom_range(wh - 1),
                  $urandom, $urandom, $urandom);
      end else if (pick < 450) begin
        if ($urandom_range(4) != 0) begin
          last_x = $urandom_range(SCREEN_W - 1);
          last_y = $urandom_range(SCREEN_H - 1);
          add_req(CMD_PIXEL, last_x, last_y, $urandom, $urandom, $urandom);
        end else begin
          add_req(CMD_PIXEL, $urandom_range(1023), $urandom_range(1023),
                  $urandom, $urandom, $urandom);
        end
      end else if (pick < 570) begin
        if ($urandom_range(9) == 0)
          add_req(CMD_RECT, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
                  $urandom_range(1023), $urandom_range(1023), $urandom);
        else if ($urandom_range(9) == 0)
          add_req(CMD_RECT, $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(12), $urandom_range(12), $urandom);
        else
          add_req(CMD_RECT, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
                  $urandom_range(12), $urandom_range(12), $urandom);
      end else if (pick < 720) begin
        k = $urandom_range(9);
        if (k < 5)
          add_req(CMD_READ, last_x, last_y, $urandom, $urandom, $urandom);
        else if (k < 9)
          add_req(CMD_READ, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
                  $urandom, $urandom, $urandom);
        else
          add_req(CMD_READ, $urandom_range(1023), $urandom_range(1023),
                  $urandom, $urandom, $urandom);
      end else if (pick < 800) begin
        add_req(CMD_WOPEN, $urandom_range(1023), $urandom_range(1023),
                $urandom_range(1023), $urandom_range(1023), $urandom);
      end else if (pick < 880) begin
        add_req(CMD_IMAGE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 900) begin
        add_req(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), $urandom, $urandom,
                $urandom, $urandom, $urandom);
      end else if (pick < 903) begin
        add_req(CMD_SCREEN, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        last_x = $urandom_range(SCREEN_W - 1);
        last_y = $urandom_range(SCREEN_H - 1);
        add_req(CMD_PIXEL, last_x, last_y, $urandom, $urandom, $urandom);
        add_req(CMD_READ, last_x, last_y, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Hold off until every queued request is sent and every result is back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_bus.valid || owed_results.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: holds a request until it is taken, then picks the next.
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        apply_draw(on_bus);
        sent_by_cmd[on_bus.cmd]++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          req_bus.valid  <= 1'b1;
          req_bus.cmd    <= on_bus.cmd;
          req_bus.pos_x  <= on_bus.x;
          req_bus.pos_y  <= on_bus.y;
          req_bus.size_w <= on_bus.w;
          req_bus.size_h <= on_bus.h;
          req_bus.colour <= on_bus.colour;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest one owed.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got status %0d read_word %h",
                   $time, rsp_bus.status, rsp_bus.read_word);
        end else begin
          due = owed_results.pop_front();
          compared++;
          if (rsp_bus.status !== due.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.status, rsp_bus.status);
          end
          if (rsp_bus.read_word !== due.read_word) begin
            mismatches++;
            $display("%0t: read_word mismatch, expected %h, got %h",
                     $time, due.read_word, rsp_bus.read_word);
          end
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    int phase;
    int src_pct[4];
    int sink_pct[4];
    src_pct  = '{0, 62, 0, 9};
    sink_pct = '{0, 0, 62, 9};
    for (int i = 0; i < FB_WORDS; i++) fb_shadow[i] = '0;
    win_x = '0;
    win_y = '0;
    win_w = '0;
    win_h = '0;
    cur_col = '0;
    cur_row = '0;
    win_open = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: corners, clipping, fills, window life cycle, spare codes.
    add_req(CMD_READ, 0, 0, 0, 0, 16'h0000);
    add_req(CMD_PIXEL, 0, 0, 1023, 1023, 16'h1234);
    add_req(CMD_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 16'hFFFF);
    add_req(CMD_PIXEL, SCREEN_W, 0, 0, 0, 16'hBEEF);
    add_req(CMD_PIXEL, 1023, 1023, 0, 0, 16'hBEEF);
    add_req(CMD_READ, 0, 0, 0, 0, 16'h0000);
    add_req(CMD_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 16'h0000);
    add_req(CMD_READ, 0, SCREEN_H, 0, 0, 16'h0000);
    add_req(CMD_RECT, SCREEN_W - 10, SCREEN_H - 5, 1023, 1023, 16'hA5C3);
    add_req(CMD_RECT, 10, 10, 0, 5, 16'h5555);
    add_req(CMD_RECT, 10, 10, 5, 0, 16'h5555);
    add_req(CMD_RECT, SCREEN_W, 10, 5, 5, 16'h5555);
    add_req(CMD_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 16'h0000);
    add_req(CMD_SCREEN, 1023, 1023, 1023, 1023, 16'h00FF);
    add_req(CMD_READ, 80, 40, 0, 0, 16'h0000);
    add_req(CMD_WOPEN, 0, 0, 4, 4, 16'h0000);
    add_req(CMD_WOPEN, SCREEN_W - 2, SCREEN_H - 2, 2, 2, 16'h0000);
    add_req(CMD_IMAGE, 0, 0, 0, 0, 16'h0001);
    add_req(CMD_IMAGE, 0, 0, 0, 0, 16'h8000);
    add_req(CMD_READ, SCREEN_W - 2, SCREEN_H - 2, 0, 0, 16'h0000);
    add_req(CMD_IMAGE, 0, 0, 0, 0, 16'hF00F);
    add_req(CMD_IMAGE, 0, 0, 0, 0, 16'h0FF0);
    add_req(CMD_IMAGE, 0, 0, 0, 0, 16'h7E7E);
    add_req(CMD_WOPEN, SCREEN_W - 10, 0, 20, 1, 16'h0000);
    add_req(CMD_WOPEN, 0, 0, 0, 3, 16'h0000);
    add_req(CMD_SPARE_LO, 0, 0, 0, 0, 16'h0000);
    add_req(CMD_SPARE_HI, 1023, 1023, 1023, 1023, 16'hFFFF);
    wait_drained();

    // Random traffic in four handshake phases, fully drained between phases.
    for (phase = 0; phase < 4; phase++) begin
      src_idle_pct = src_pct[phase];
      sink_stall_pct = sink_pct[phase];
      queue_random(queued_total + RANDOM_REQS / 4);
      wait_drained();
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d requests: pixel %0d, rect %0d, screen %0d, window %0d, image %0d",
             queued_total, sent_by_cmd[CMD_PIXEL], sent_by_cmd[CMD_RECT],
             sent_by_cmd[CMD_SCREEN], sent_by_cmd[CMD_WOPEN], sent_by_cmd[CMD_IMAGE]);
    $display("summary: read %0d, spare codes %0d; %0d results compared, %0d mismatches",
             sent_by_cmd[CMD_READ], sent_by_cmd[CMD_SPARE_LO] + sent_by_cmd[CMD_SPARE_HI],
             compared, mismatches);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the clear after reset.
  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
